// File: design/imubfc_pkg.sv
package imubfc_pkg;

  localparam int DIAG_LO_POS   = 2;
  localparam int DIAG_HI_POS   = 3;
  localparam int PAYLOAD_START = 4;
  localparam int SELF_TEST_BIT = 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0] CRC_LUT [256] = '{
    16'h0000, 16'h17CE, 16'h0FDF, 16'h1811, 16'h1FBE, 16'h0870, 16'h1061, 16'h07AF,
    16'h1F3F, 16'h08F1, 16'h10E0, 16'h072E, 16'h0081, 16'h174F, 16'h0F5E, 16'h1890,
    16'h1E3D, 16'h09F3, 16'h11E2, 16'h062C, 16'h0183, 16'h164D, 16'h0E5C, 16'h1992,
    16'h0102, 16'h16CC, 16'h0EDD, 16'h1913, 16'h1EBC, 16'h0972, 16'h1163, 16'h06AD,
    16'h1C39, 16'h0BF7, 16'h13E6, 16'h0428, 16'h0387, 16'h1449, 16'h0C58, 16'h1B96,
    16'h0306, 16'h14C8, 16'h0CD9, 16'h1B17, 16'h1CB8, 16'h0B76, 16'h1367, 16'h04A9,
    16'h0204, 16'h15CA, 16'h0DDB, 16'h1A15, 16'h1DBA, 16'h0A74, 16'h1265, 16'h05AB,
    16'h1D3B, 16'h0AF5, 16'h12E4, 16'h052A, 16'h0285, 16'h154B, 16'h0D5A, 16'h1A94,
    16'h1831, 16'h0FFF, 16'h17EE, 16'h0020, 16'h078F, 16'h1041, 16'h0850, 16'h1F9E,
    16'h070E, 16'h10C0, 16'h08D1, 16'h1F1F, 16'h18B0, 16'h0F7E, 16'h176F, 16'h00A1,
    16'h060C, 16'h11C2, 16'h09D3, 16'h1E1D, 16'h19B2, 16'h0E7C, 16'h166D, 16'h01A3,
    16'h1933, 16'h0EFD, 16'h16EC, 16'h0122, 16'h068D, 16'h1143, 16'h0952, 16'h1E9C,
    16'h0408, 16'h13C6, 16'h0BD7, 16'h1C19, 16'h1BB6, 16'h0C78, 16'h1469, 16'h03A7,
    16'h1B37, 16'h0CF9, 16'h14E8, 16'h0326, 16'h0489, 16'h1347, 16'h0B56, 16'h1C98,
    16'h1A35, 16'h0DFB, 16'h15EA, 16'h0224, 16'h058B, 16'h1245, 16'h0A54, 16'h1D9A,
    16'h050A, 16'h12C4, 16'h0AD5, 16'h1D1B, 16'h1AB4, 16'h0D7A, 16'h156B, 16'h02A5,
    16'h1021, 16'h07EF, 16'h1FFE, 16'h0830, 16'h0F9F, 16'h1851, 16'h0040, 16'h178E,
    16'h0F1E, 16'h18D0, 16'h00C1, 16'h170F, 16'h10A0, 16'h076E, 16'h1F7F, 16'h08B1,
    16'h0E1C, 16'h19D2, 16'h01C3, 16'h160D, 16'h11A2, 16'h066C, 16'h1E7D, 16'h09B3,
    16'h1123, 16'h06ED, 16'h1EFC, 16'h0932, 16'h0E9D, 16'h1953, 16'h0142, 16'h168C,
    16'h0C18, 16'h1BD6, 16'h03C7, 16'h1409, 16'h13A6, 16'h0468, 16'h1C79, 16'h0BB7,
    16'h1327, 16'h04E9, 16'h1CF8, 16'h0B36, 16'h0C99, 16'h1B57, 16'h0346, 16'h1488,
    16'h1225, 16'h05EB, 16'h1DFA, 16'h0A34, 16'h0D9B, 16'h1A55, 16'h0244, 16'h158A,
    16'h0D1A, 16'h1AD4, 16'h02C5, 16'h150B, 16'h12A4, 16'h056A, 16'h1D7B, 16'h0AB5,
    16'h0810, 16'h1FDE, 16'h07CF, 16'h1001, 16'h17AE, 16'h0060, 16'h1871, 16'h0FBF,
    16'h172F, 16'h00E1, 16'h18F0, 16'h0F3E, 16'h0891, 16'h1F5F, 16'h074E, 16'h1080,
    16'h162D, 16'h01E3, 16'h19F2, 16'h0E3C, 16'h0993, 16'h1E5D, 16'h064C, 16'h1182,
    16'h0912, 16'h1EDC, 16'h06CD, 16'h1103, 16'h16AC, 16'h0162, 16'h1973, 16'h0EBD,
    16'h1429, 16'h03E7, 16'h1BF6, 16'h0C38, 16'h0B97, 16'h1C59, 16'h0448, 16'h1386,
    16'h0B16, 16'h1CD8, 16'h04C9, 16'h1307, 16'h14A8, 16'h0366, 16'h1B77, 16'h0CB9,
    16'h0A14, 16'h1DDA, 16'h05CB, 16'h1205, 16'h15AA, 16'h0264, 16'h1A75, 16'h0DBB,
    16'h152B, 16'h02E5, 16'h1AF4, 16'h0D3A, 16'h0A95, 16'h1D5B, 16'h054A, 16'h1284
  };

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return {8'h00, crc[15:8]} ^ CRC_LUT[idx];
  endfunction

endpackage

// File: design/imubfc_if.sv
interface imubfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface imubfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_calc;
  logic [15:0] crc_recv;
  logic        crc_match;
  logic        self_test_failed;
  logic [15:0] diag_word;

  modport source (output valid, output crc_calc, output crc_recv,
                  output crc_match, output self_test_failed, output diag_word,
                  input ready);
  modport sink (input valid, input crc_calc, input crc_recv,
                input crc_match, input self_test_failed, input diag_word,
                output ready);
endinterface

// File: design/imubfc_crc_pair.sv
module imubfc_crc_pair
  import imubfc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  first_byte,
  output logic [15:0] crc_out
);

  logic [15:0] crc_mid;

  // The second byte of a word enters the CRC before the first.
  assign crc_mid = crc_feed(crc_in, second_byte);
  assign crc_out = crc_feed(crc_mid, first_byte);

endmodule

// File: design/imu_burst_frame_checker_core.sv
// The input stage registers a byte at acceptance and processes it from there; the
// result of a frame is registered in the output stage when its last byte is processed.
// Throughput: one byte per cycle; the two chained CRC table lookups of a word are
// combinational. A result held by the sink stalls the input.
// Reset (rst_n low, synchronous): byte position 0, CRC 0xFFFF, held byte, diagnostic
// word and received CRC high byte cleared, no transaction pending on either side.
module imu_burst_frame_checker_core
  import imubfc_pkg::*;
#(
  parameter int PAYLOAD_WORDS = 11,
  parameter int FRAME_BYTES   = 28
) (
  input  logic clk,
  input  logic rst_n,
  imubfc_in_if.sink    in_chan,
  imubfc_out_if.source out_chan
);

  localparam int POS_W   = $clog2(FRAME_BYTES + 1);
  localparam int PAY_END = PAYLOAD_START + 2 * PAYLOAD_WORDS;

  localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_RX_HI  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_RX_LO  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DIAG_L = POS_W'(DIAG_LO_POS);
  localparam logic [POS_W-1:0] POS_DIAG_H = POS_W'(DIAG_HI_POS);

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             s1_advance;
  logic             out_free;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [15:0]      diag_r, diag_nxt;
  logic [7:0]       rx_hi_r, rx_hi_nxt;

  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_base;
  logic [15:0]      crc_word;
  logic [15:0]      crc_inv;
  logic [15:0]      calc_crc;
  logic [15:0]      rx_crc;
  logic             emit;
  logic             in_payload;

  logic             out_valid_r;
  logic [15:0]      out_calc_r;
  logic [15:0]      out_rx_r;
  logic             out_match_r;
  logic             out_stf_r;
  logic [15:0]      out_diag_r;

  assign out_free   = !out_valid_r || out_chan.ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_start_r <= in_chan.frame_start;
    end
  end

  assign pos_eff    = s1_start_r ? '0 : pos_r;
  assign crc_base   = (pos_eff == '0) ? CRC_INIT : crc_r;
  assign in_payload = (32'(pos_eff) >= 32'(PAYLOAD_START)) && (32'(pos_eff) < 32'(PAY_END));

  imubfc_crc_pair u_crc_pair (
    .crc_in      (crc_base),
    .second_byte (s1_byte_r),
    .first_byte  (held_r),
    .crc_out     (crc_word)
  );

  assign crc_inv  = ~crc_base;
  assign calc_crc = {crc_inv[7:0], crc_inv[15:8]};
  assign rx_crc   = {rx_hi_r, s1_byte_r};

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    held_nxt  = held_r;
    diag_nxt  = diag_r;
    rx_hi_nxt = rx_hi_r;
    emit      = 1'b0;
    if (s1_advance) begin
      if (s1_start_r) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end
      if (pos_eff < POS_IDLE) begin
        crc_nxt = crc_base;
        pos_nxt = pos_eff + 1'b1;
        priority if (pos_eff == POS_DIAG_L) begin
          diag_nxt[7:0] = s1_byte_r;
        end else if (pos_eff == POS_DIAG_H) begin
          diag_nxt[15:8] = s1_byte_r;
        end else if (pos_eff == POS_RX_HI) begin
          rx_hi_nxt = s1_byte_r;
        end else if (pos_eff == POS_RX_LO) begin
          emit    = 1'b1;
          pos_nxt = POS_IDLE;
        end else begin
          if (in_payload) begin
            if (!pos_eff[0]) begin
              held_nxt = s1_byte_r;
            end else begin
              crc_nxt = crc_word;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      held_r  <= '0;
      diag_r  <= '0;
      rx_hi_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      held_r  <= held_nxt;
      diag_r  <= diag_nxt;
      rx_hi_r <= rx_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
    if (emit) begin
      out_calc_r  <= calc_crc;
      out_rx_r    <= rx_crc;
      out_match_r <= (calc_crc == rx_crc);
      out_stf_r   <= diag_r[SELF_TEST_BIT];
      out_diag_r  <= diag_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.crc_calc         = out_calc_r;
  assign out_chan.crc_recv         = out_rx_r;
  assign out_chan.crc_match        = out_match_r;
  assign out_chan.self_test_failed = out_stf_r;
  assign out_chan.diag_word        = out_diag_r;

endmodule

// File: design/imubfc_checker.sv
module imubfc_checker
  import imubfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] crc_calc,
  input logic [15:0] crc_recv,
  input logic        crc_match,
  input logic        self_test_failed,
  input logic [15:0] diag_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (crc_match == (crc_calc == crc_recv)))
    else $error("CRC match flag disagrees with the CRC fields.");

  a_self_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (self_test_failed == diag_word[SELF_TEST_BIT]))
    else $error("Self-test flag disagrees with the diagnostic word.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind imu_burst_frame_checker_core imubfc_checker u_imubfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .crc_calc         (out_chan.crc_calc),
  .crc_recv         (out_chan.crc_recv),
  .crc_match        (out_chan.crc_match),
  .self_test_failed (out_chan.self_test_failed),
  .diag_word        (out_chan.diag_word)
);
